// ----- hw/rtl/vklr_pkg.sv -----
// Shared types and constants for the key length ranker.
package vklr_pkg;

   // Action codes carried by an input item.
   localparam logic [1:0] ACT_CLEAR   = 2'd0;
   localparam logic [1:0] ACT_APPEND  = 2'd1;
   localparam logic [1:0] ACT_ANALYZE = 2'd2;

   // Result status codes.
   localparam logic STAT_OK      = 1'b0;
   localparam logic STAT_NO_TEXT = 1'b1;

   localparam int          ALPHA      = 26;
   localparam logic [7:0]  CHAR_UA    = 8'h41;
   localparam logic [7:0]  CHAR_UZ    = 8'h5A;
   localparam logic [7:0]  CHAR_LA    = 8'h61;
   localparam logic [7:0]  CHAR_LZ    = 8'h7A;
   localparam int          IC_W       = 21;
   localparam int          FRAC_SHIFT = 17;  // Q16 scale times the factor two of c*(c-1)
   localparam logic [20:0] IC_MAX     = 21'd1703936;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [5:0]  rank_len;
      logic [20:0] ic_value;
      logic        status;
      logic        last;
   } rsp_type;

endpackage

// ----- hw/rtl/vklr_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module vklr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- hw/rtl/vklr_div.sv -----
// Restoring divider producing one quotient bit per cycle.
module vklr_div #(
   parameter int NW = 48,
   parameter int DW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo,
   output logic          done
);

   localparam int SW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] step_ff, step_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;

   // One shift and trial subtraction per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[NW-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = SW'(NW);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         step_in = step_ff - SW'(1);
         if (step_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

// ----- hw/rtl/vigenere_key_length_ic_ranker_top.sv -----
// Top level of the key length ranker: letter store, column scan, scoring and ranking.
// Clear and append items are taken one per cycle. An analyze item holds req_ready low
// while it walks the store: for every candidate length L each of the L columns is read
// from the letter RAM one letter per cycle, each column with two or more letters costs
// one pass of the shared serial divider, which has NW quotient bits (the larger of
// 2*ceil(log2(MAX_TEXT+1)) + 22 and IC_W + KW, 48 by default), the average costs one
// more pass, and the sorted insertion compares and moves entries from the back of the
// list. Results then leave one at a time, each read from the rank RAM and then loaded
// when rsp_ready is high or no response is held. The letter RAM read port and the
// divider set the analyze time.
module vigenere_key_length_ic_ranker_top #(
   parameter int MAX_TEXT = 4096,
   parameter int MAX_KEY  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vklr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vklr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [5:0]       csr_data
);

   import vklr_pkg::*;

   localparam int CW  = $clog2(MAX_TEXT + 1);
   localparam int AW  = $clog2(MAX_TEXT);
   localparam int IW  = $clog2(MAX_TEXT + MAX_KEY + 1);
   localparam int KW  = $clog2(MAX_KEY + 1);
   localparam int RAW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
   localparam int PW  = 2 * CW;
   localparam int TW  = IC_W + KW;
   localparam int NW  = (PW + 22 > TW) ? PW + 22 : TW;
   localparam int DW  = (PW > KW) ? PW : KW;
   localparam int RW  = KW + IC_W;

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_NOTEXT = 4'd1;
   localparam logic [3:0] S_LEN    = 4'd2;
   localparam logic [3:0] S_COL    = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_MUL    = 4'd5;
   localparam logic [3:0] S_CDIV   = 4'd6;
   localparam logic [3:0] S_CWAIT  = 4'd7;
   localparam logic [3:0] S_ACC    = 4'd8;
   localparam logic [3:0] S_ADIV   = 4'd9;
   localparam logic [3:0] S_AWAIT  = 4'd10;
   localparam logic [3:0] S_INSRD  = 4'd11;
   localparam logic [3:0] S_INSCMP = 4'd12;
   localparam logic [3:0] S_OUTRD  = 4'd13;
   localparam logic [3:0] S_OUTLD  = 4'd14;

   logic [3:0]     state_ff, state_in;
   logic [5:0]     max_key_len_ff, max_key_len_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [KW-1:0]  lim_ff, lim_in;
   logic [KW-1:0]  len_ff, len_in;
   logic [KW-1:0]  col_ff, col_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           pend_ff, pend_in;
   logic [CW-1:0]  n_ff, n_in;
   logic [PW-1:0]  pairs_ff, pairs_in;
   logic [CW-1:0]  cnt_ff [0:ALPHA-1];
   logic [CW-1:0]  cnt_in [0:ALPHA-1];
   logic [PW-1:0]  den_ff, den_in;
   logic [TW-1:0]  total_ff, total_in;
   logic [IC_W-1:0] score_ff, score_in;
   logic [RAW-1:0] pos_ff, pos_in;
   logic [RAW-1:0] k_ff, k_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic           txt_we;
   logic [AW-1:0]  txt_waddr, txt_raddr;
   logic [4:0]     txt_wdata, txt_rdata;
   logic           rk_we;
   logic [RAW-1:0] rk_waddr, rk_raddr;
   logic [RW-1:0]  rk_wdata, rk_rdata;
   logic           div_start, div_done;
   logic [NW-1:0]  div_num, div_quo;
   logic [DW-1:0]  div_den;

   logic           is_upper, is_lower;
   logic [4:0]     code;
   logic [KW-1:0]  lim_c;
   logic           slot_free;
   logic           accept;
   logic [IC_W-1:0] rk_old_score;

   vklr_ram #(.WIDTH(5), .DEPTH(MAX_TEXT)) u_text (
      .clock (clock),
      .we    (txt_we),
      .waddr (txt_waddr),
      .wdata (txt_wdata),
      .raddr (txt_raddr),
      .rdata (txt_rdata)
   );

   vklr_ram #(.WIDTH(RW), .DEPTH(MAX_KEY)) u_rank (
      .clock (clock),
      .we    (rk_we),
      .waddr (rk_waddr),
      .wdata (rk_wdata),
      .raddr (rk_raddr),
      .rdata (rk_rdata)
   );

   vklr_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   assign accept       = req_valid && req_ready;
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign rk_old_score = rk_rdata[IC_W-1:0];

   // Letter decode with case folding.
   always_comb begin
      is_upper = (req_data.char_in >= CHAR_UA) && (req_data.char_in <= CHAR_UZ);
      is_lower = (req_data.char_in >= CHAR_LA) && (req_data.char_in <= CHAR_LZ);
      code     = is_upper ? 5'(req_data.char_in - CHAR_UA) : 5'(req_data.char_in - CHAR_LA);
   end

   // Number of candidate lengths, clamped to the register range and the text length.
   always_comb begin
      if (max_key_len_ff == 6'd0) begin
         lim_c = KW'(1);
      end else if (32'(max_key_len_ff) > 32'(MAX_KEY)) begin
         lim_c = KW'(MAX_KEY);
      end else begin
         lim_c = KW'(max_key_len_ff);
      end
      if (32'(lim_c) > 32'(count_ff)) begin
         lim_c = KW'(count_ff);
      end
   end

   // Main sequencer.
   always_comb begin
      state_in       = state_ff;
      max_key_len_in = max_key_len_ff;
      count_in       = count_ff;
      lim_in         = lim_ff;
      len_in         = len_ff;
      col_in         = col_ff;
      idx_in         = idx_ff;
      pend_in        = 1'b0;
      n_in           = n_ff;
      pairs_in       = pairs_ff;
      cnt_in         = cnt_ff;
      den_in         = den_ff;
      total_in       = total_ff;
      score_in       = score_ff;
      pos_in         = pos_ff;
      k_in           = k_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      txt_we         = 1'b0;
      txt_waddr      = count_ff[AW-1:0];
      txt_wdata      = code;
      txt_raddr      = idx_ff[AW-1:0];
      rk_we          = 1'b0;
      rk_waddr       = pos_ff;
      rk_wdata       = {len_ff, score_ff};
      rk_raddr       = (state_ff == S_INSRD) ? RAW'(pos_ff - RAW'(1)) : k_ff;
      div_start      = 1'b0;
      div_num        = NW'(pairs_ff) * NW'(ALPHA) << FRAC_SHIFT;
      div_den        = DW'(den_ff);
      req_ready      = (state_ff == S_IDLE);

      // The single register is written whenever the port offers it.
      if (csr_valid) begin
         max_key_len_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_APPEND: begin
                     if ((is_upper || is_lower) && (32'(count_ff) < 32'(MAX_TEXT))) begin
                        txt_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ACT_ANALYZE: begin
                     lim_in = lim_c;
                     len_in = KW'(1);
                     if (count_ff == '0) begin
                        state_in = S_NOTEXT;
                     end else begin
                        state_in = S_LEN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_NOTEXT: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.rank_len = '0;
               rsp_data_in.ic_value = '0;
               rsp_data_in.status   = STAT_NO_TEXT;
               rsp_data_in.last     = 1'b1;
               state_in             = S_IDLE;
            end
         end
         S_LEN: begin
            col_in   = '0;
            total_in = '0;
            state_in = S_COL;
         end
         S_COL: begin
            for (int i = 0; i < ALPHA; i++) begin
               cnt_in[i] = '0;
            end
            n_in     = '0;
            pairs_in = '0;
            idx_in   = IW'(col_ff);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // Issue one read per cycle; the letter returned in the next cycle is counted.
            if (idx_ff < IW'(count_ff)) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + IW'(len_ff);
            end else if (!pend_ff) begin
               state_in = (n_ff < CW'(2)) ? S_ACC : S_MUL;
            end
            if (pend_ff) begin
               pairs_in           = pairs_ff + PW'(cnt_ff[txt_rdata]);
               cnt_in[txt_rdata]  = cnt_ff[txt_rdata] + CW'(1);
               n_in               = n_ff + CW'(1);
            end
         end
         S_MUL: begin
            den_in   = PW'(n_ff) * PW'(n_ff - CW'(1));
            state_in = S_CDIV;
         end
         S_CDIV: begin
            div_start = 1'b1;
            state_in  = S_CWAIT;
         end
         S_CWAIT: begin
            if (div_done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (n_ff >= CW'(2)) begin
               total_in = total_ff + TW'(div_quo[IC_W-1:0]);
            end
            col_in = col_ff + KW'(1);
            if (col_ff + KW'(1) == len_ff) begin
               state_in = S_ADIV;
            end else begin
               state_in = S_COL;
            end
         end
         S_ADIV: begin
            div_start = 1'b1;
            div_num   = NW'(total_ff);
            div_den   = DW'(len_ff);
            state_in  = S_AWAIT;
         end
         S_AWAIT: begin
            if (div_done) begin
               score_in = div_quo[IC_W-1:0];
               pos_in   = RAW'(len_ff - KW'(1));
               state_in = S_INSRD;
            end
         end
         S_INSRD: begin
            // Front of the list reached: place the new entry.
            if (pos_ff == '0) begin
               rk_we = 1'b1;
               if (len_ff == lim_ff) begin
                  k_in     = '0;
                  state_in = S_OUTRD;
               end else begin
                  len_in   = len_ff + KW'(1);
                  state_in = S_LEN;
               end
            end else begin
               state_in = S_INSCMP;
            end
         end
         S_INSCMP: begin
            rk_we = 1'b1;
            if (rk_old_score < score_ff) begin
               // Move the weaker entry one place back and keep looking.
               rk_wdata = rk_rdata;
               pos_in   = pos_ff - RAW'(1);
               state_in = S_INSRD;
            end else if (len_ff == lim_ff) begin
               k_in     = '0;
               state_in = S_OUTRD;
            end else begin
               len_in   = len_ff + KW'(1);
               state_in = S_LEN;
            end
         end
         S_OUTRD: begin
            state_in = S_OUTLD;
         end
         S_OUTLD: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.rank_len = 6'(rk_rdata[RW-1:IC_W]);
               rsp_data_in.ic_value = rk_old_score;
               rsp_data_in.status   = STAT_OK;
               rsp_data_in.last     = (32'(k_ff) + 1 == 32'(lim_ff));
               if (32'(k_ff) + 1 == 32'(lim_ff)) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + RAW'(1);
                  state_in = S_OUTRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         max_key_len_ff <= 6'd32;
         count_ff       <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         max_key_len_ff <= max_key_len_in;
         count_ff       <= count_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      lim_ff      <= lim_in;
      len_ff      <= len_in;
      col_ff      <= col_in;
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      pairs_ff    <= pairs_in;
      cnt_ff      <= cnt_in;
      den_ff      <= den_in;
      total_ff    <= total_in;
      score_ff    <= score_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_TEXT))
      else $error("letter count beyond store capacity");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_CWAIT || state_ff == S_AWAIT))
      else $error("divider finished outside a wait state");

   a_ic_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.ic_value <= IC_MAX))
      else $error("score above the largest possible index");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (pend_ff || div_done) |-> !req_ready)
      else $error("item taken while an analysis is running");
`endif

endmodule
